// ----- design/pidarr_pkg.sv -----
// Package for the positional insert/delete array unit.
// Field widths, command and status codes, and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pidarr_pkg;

    localparam int OP_W     = 3;
    localparam int IDX_W    = 7;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd4;
    localparam logic [OP_W-1:0] OP_READ   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // broadcast to every cell; at most one flag set per cycle
    typedef struct packed {
        logic shift_up;    // insert: cells above target take left neighbor
        logic shift_down;  // delete: cells at/above target take right neighbor
        logic write;       // append/update: cell at target takes value
    } pidarr_ctl_t;

endpackage

`default_nettype wire

// ----- design/pidarr_in_if.sv -----
// Request channel of the positional insert/delete array unit.
// Valid/ready handshake with command payload; depends on pidarr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pidarr_in_if
    import pidarr_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output op, output index, output value, input ready);
    modport sink   (input valid, input op, input index, input value, output ready);
endinterface

`default_nettype wire

// ----- design/pidarr_out_if.sv -----
// Result channel of the positional insert/delete array unit.
// Valid/ready handshake with result payload; depends on pidarr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pidarr_out_if
    import pidarr_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output read_value, output count, output status,
                    input ready);
    modport sink   (input valid, input read_value, input count, input status,
                    output ready);
endinterface

`default_nettype wire

// ----- design/pidarr_cell.sv -----
// One storage cell of the array chain: holds one entry and takes its
// own, its neighbor's or the broadcast value. Depends on pidarr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidarr_cell
    import pidarr_pkg::*;
#(
    parameter int TGT_W = 7,
    parameter int POS   = 0
)(
    input  wire logic                     clk,
    input  wire pidarr_ctl_t              ctl,
    input  wire logic [TGT_W-1:0]         target,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic signed [DATA_W-1:0] left,
    input  wire logic signed [DATA_W-1:0] right,
    output logic signed [DATA_W-1:0]      data
);

    localparam logic [TGT_W-1:0] MY_POS = TGT_W'(POS);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     at_target;
    logic                     above_target;

    assign at_target    = (target == MY_POS);
    assign above_target = (MY_POS > target);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift_up)
        begin
            if (above_target)
                data_next = left;
            else if (at_target)
                data_next = value;
        end
        else if (ctl.shift_down)
        begin
            if (above_target || at_target)
                data_next = right;
        end
        else if (ctl.write && at_target)
        begin
            data_next = value;
        end
    end

    // entry storage, undefined until written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ----- design/positional_insert_delete_array_unit.sv -----
// Positional insert/delete array unit: top level.
// Uses pidarr_pkg, pidarr_in_if, pidarr_out_if and pidarr_cell.
//
// Usage:
//   in  : request channel (op, index, value); taken when valid && ready.
//   out : result channel (read_value, count, status), one result per request.
//   Each request is decoded and checked against the fill count in the
//   accept cycle; every cell of the chain updates at that edge (insert and
//   delete shift the entries at and above the index by one place at once),
//   and the result lands in the output register, valid in the cycle after
//   accept. Throughput: one request per cycle while out.ready is high,
//   set by the cell update and the read select over all cells.
//   A waiting result holds in.ready low until out.ready takes it; when
//   out.ready is high a new request is taken in the same cycle the old
//   result leaves.
//   Reset clears the fill count and the output valid; entry contents stay
//   undefined until written. Clear only zeroes the count.
//   On error (full or index out of range) the array and count are unchanged.
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_delete_array_unit
    import pidarr_pkg::*;
#(
    parameter int CAPACITY = 128
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    pidarr_in_if.sink     in,
    pidarr_out_if.source  out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] read_value_reg;
    logic [COUNT_W-1:0]       count_out_reg;
    logic [STATUS_W-1:0]      status_reg;

    logic                     accept;
    logic                     full;
    logic [CMP_W-1:0]         idx_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic [CMP_W-1:0]         target;
    pidarr_ctl_t              ctl;
    logic [STATUS_W-1:0]      status_next;
    logic signed [DATA_W-1:0] read_value_next;
    logic signed [DATA_W-1:0] read_sel;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    assign in.ready = !out_valid_reg || out.ready;
    assign accept   = in.valid && in.ready;
    assign full     = (count_reg >= CAP_CNT);
    assign idx_ext  = CMP_W'(in.index);
    assign cnt_ext  = CMP_W'(count_reg);

    // select entry at index: AND-OR over all cells
    always_comb
    begin
        read_sel = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (idx_ext == CMP_W'(k))
                read_sel = read_sel | cell_data[k];
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        status_next     = ST_OK;
        read_value_next = '0;
        target          = idx_ext;
        ctl             = '0;
        case (in.op)
            OP_CLEAR:
            begin
                count_next = '0;
            end
            OP_APPEND:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    ctl.write  = accept;
                    target     = cnt_ext;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
                else if (idx_ext > cnt_ext)
                    status_next = ST_RANGE;
                else
                begin
                    ctl.shift_up = accept;
                    count_next   = count_reg + 1'b1;
                end
            end
            OP_UPDATE:
            begin
                if (idx_ext >= cnt_ext)
                    status_next = ST_RANGE;
                else
                    ctl.write = accept;
            end
            OP_DELETE:
            begin
                if (idx_ext >= cnt_ext)
                    status_next = ST_RANGE;
                else
                begin
                    ctl.shift_down = accept;
                    count_next     = count_reg - 1'b1;
                end
            end
            OP_READ:
            begin
                if (idx_ext >= cnt_ext)
                    status_next = ST_RANGE;
                else
                    read_value_next = read_sel;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_data;
            logic signed [DATA_W-1:0] right_data;

            if (g == 0)
            begin : g_first
                assign left_data = cell_data[g];
            end
            else
            begin : g_mid_l
                assign left_data = cell_data[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign right_data = cell_data[g];
            end
            else
            begin : g_mid_r
                assign right_data = cell_data[g+1];
            end

            pidarr_cell #(
                .TGT_W (CMP_W),
                .POS   (g)
            ) u_cell (
                .clk    (clk),
                .ctl    (ctl),
                .target (target),
                .value  (in.value),
                .left   (left_data),
                .right  (right_data),
                .data   (cell_data[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg <= read_value_next;
            count_out_reg  <= COUNT_W'(count_next);
            status_reg     <= status_next;
        end
    end

    assign out.valid      = out_valid_reg;
    assign out.read_value = read_value_reg;
    assign out.count      = count_out_reg;
    assign out.status     = status_reg;

    // fill count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("fill count above capacity");

    // a stalled result blocks new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && !out.ready) |-> !in.ready)
        else $error("request taken while result stalled");

    // clear gives an empty array with ok status
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in.op == OP_CLEAR) |=>
            (out.valid && out.count == '0 && out.status == ST_OK))
        else $error("clear did not empty the array");

    // an error leaves the fill count unchanged
    a_error_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (out.status == ST_OK || count_reg == $past(count_reg)))
        else $error("count changed on error");

endmodule

`default_nettype wire
